// ===== rtl/ack_pkg.sv =====
// Package for the AES counter-mode keystream block.
// Holds the S-box, GF(2^8) helpers, round transform and key-length codes.
package ack_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int NR_MAX     = 14;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2,
        KEY_RSV = 2'd3
    } key_len_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXPAND = 2'd1,
        ST_RUN    = 2'd2,
        ST_DRAIN  = 2'd3
    } ctl_state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // One AES round on a byte-0-in-bits-7:0 state; last drops MixColumns
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[4*c+i] = sbox(s[8*(4*((c+i)%4)+i) +: 8]);
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            r[8*i +: 8] = t[i];
        return r ^ rk;
    endfunction

endpackage

// ===== rtl/ack_key_expand.sv =====
// Key schedule: one 32-bit word per cycle into a round-key store.
// Depends on ack_pkg.
module ack_key_expand
    import ack_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic [255:0]   key,
    input  logic [3:0]     nk,
    output logic           done,
    output logic [127:0]   round_key [NR_MAX+1]
);

    localparam int WORDS = 4 * (NR_MAX + 1);

    logic [31:0] w_reg [WORDS];
    logic [5:0]  idx_reg, idx_next;
    logic [5:0]  total_reg;
    logic [3:0]  nk_reg;
    logic [3:0]  mod_reg, mod_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic        busy_reg;
    logic [31:0] prev, back, temp;

    // the previous word and the word Nk back are read from the store
    always_comb
    begin
        prev = w_reg[idx_reg - 6'd1];
        back = w_reg[idx_reg - {2'b00, nk_reg}];
        temp = prev;
        if (mod_reg == 4'd0)
            temp = sub_word({prev[7:0], prev[31:8]}) ^ {24'h0, rcon_reg};
        else if (nk_reg == 4'd8 && mod_reg == 4'd4)
            temp = sub_word(prev);
        idx_next  = idx_reg + 6'd1;
        mod_next  = (mod_reg + 4'd1 == nk_reg) ? 4'd0 : mod_reg + 4'd1;
        rcon_next = (mod_reg == 4'd0) ? xtime(rcon_reg) : rcon_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            total_reg <= '0;
            nk_reg    <= 4'd4;
            mod_reg   <= '0;
            rcon_reg  <= 8'h01;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            idx_reg   <= {2'b00, nk};
            total_reg <= 6'(4 * (nk + 4'd7));
            nk_reg    <= nk;
            mod_reg   <= '0;
            rcon_reg  <= 8'h01;
        end
        else if (busy_reg)
        begin
            idx_reg  <= idx_next;
            mod_reg  <= mod_next;
            rcon_reg <= rcon_next;
            if (idx_next == total_reg)
                busy_reg <= 1'b0;
        end
    end

    // word store
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 8; i++)
                w_reg[i] <= key[32*i +: 32];
        end
        else if (busy_reg)
            w_reg[idx_reg] <= back ^ temp;
    end

    assign done = !busy_reg && !load;

    always_comb
    begin
        for (int r = 0; r <= NR_MAX; r++)
            round_key[r] = {w_reg[4*r+3], w_reg[4*r+2], w_reg[4*r+1], w_reg[4*r]};
    end

endmodule

// ===== rtl/aes_counter_keystream.sv =====
// AES counter-mode keystream generator, top level.
// Depends on ack_pkg, ack_key_expand.
//
// A request (start while busy is low) first runs the key schedule of
// 4*(Nr+1)-Nk words (40/46/52 for AES-128/192/256); then one counter block
// enters the 15-stage round pipeline every cycle, and results leave one per
// cycle on result_valid once they have passed the pipeline. Busy stays high
// until the schedule, all N blocks and the pipeline drain are done. The
// receiver cannot stall results.
module aes_counter_keystream
    import ack_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] key_word_0,
    input  logic [63:0] key_word_1,
    input  logic [63:0] key_word_2,
    input  logic [63:0] key_word_3,
    input  logic [63:0] nonce_prefix,
    input  logic [63:0] counter_start,
    input  logic [6:0]  block_count,
    output logic        result_valid,
    output logic [63:0] stream_low,
    output logic [63:0] stream_high,
    output logic [5:0]  block_index,
    output logic        last_block
);

    localparam int STAGES = NR_MAX + 1;

    key_len_t    klen_reg;
    ctl_state_t  state_reg, state_next;
    logic [63:0] nonce_reg, ctr_reg, ctr_next;
    logic [6:0]  left_reg, left_next;
    logic [5:0]  idx_reg, idx_next;
    logic [3:0]  nr_reg;
    logic [3:0]  nk;
    logic        accept, ks_done, issue;
    logic [127:0] rk [NR_MAX+1];

    logic [127:0] st_reg   [STAGES];
    logic         v_reg    [STAGES];
    logic [5:0]   bi_reg   [STAGES];
    logic         lb_reg   [STAGES];
    logic [STAGES-1:0] drain_any;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        unique case (klen_reg)
            KEY_128: nk = 4'd4;
            KEY_192: nk = 4'd6;
            default: nk = 4'd8;
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            klen_reg <= KEY_128;
        else if (cfg_write)
            klen_reg <= key_len_t'(cfg_data);
    end

    ack_key_expand u_kexp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .key       ({key_word_3, key_word_2, key_word_1, key_word_0}),
        .nk        (nk),
        .done      (ks_done),
        .round_key (rk)
    );

    // request sequencer
    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        ctr_next   = ctr_reg;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_EXPAND;
            ST_EXPAND:
                if (ks_done)
                    state_next = (left_reg == 7'd0) ? ST_DRAIN : ST_RUN;
            ST_RUN:
            begin
                issue     = 1'b1;
                left_next = left_reg - 7'd1;
                idx_next  = idx_reg + 6'd1;
                ctr_next  = ctr_reg + 64'd1;
                if (left_reg == 7'd1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                if (drain_any == '0)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            left_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                left_reg <= (block_count > 7'(MAX_BLOCKS)) ? 7'(MAX_BLOCKS) : block_count;
                idx_reg  <= '0;
            end
            else
            begin
                left_reg <= left_next;
                idx_reg  <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nonce_reg <= nonce_prefix;
            ctr_reg   <= counter_start;
            nr_reg    <= nk + 4'd6;
        end
        else
            ctr_reg <= ctr_next;
    end

    // round pipeline: stage 0 whitening, stage r round r; rounds past Nr pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
                v_reg[s] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= issue;
            for (int s = 1; s < STAGES; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= {ctr_reg, nonce_reg} ^ rk[0];
        bi_reg[0] <= idx_reg;
        lb_reg[0] <= (left_reg == 7'd1);
        for (int s = 1; s < STAGES; s++)
        begin
            bi_reg[s] <= bi_reg[s-1];
            lb_reg[s] <= lb_reg[s-1];
            if (4'(s) <= nr_reg)
                st_reg[s] <= aes_round(st_reg[s-1], rk[s], 4'(s) == nr_reg);
            else
                st_reg[s] <= st_reg[s-1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
            drain_any[s] = v_reg[s];
    end

    assign result_valid = v_reg[STAGES-1];
    assign stream_low   = st_reg[STAGES-1][63:0];
    assign stream_high  = st_reg[STAGES-1][127:64];
    assign block_index  = bi_reg[STAGES-1];
    assign last_block   = lb_reg[STAGES-1];

    // checks
    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !issue) else $error("issue while idle");
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> drain_any == '0) else $error("pipe busy when idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        issue && left_reg == 7'd1 |=> state_reg == ST_DRAIN) else $error("last not final");

endmodule
